### src/mfm_write_interval_decoder_assert.svh
// ----------------------------------------------------------------------------
// MFM write interval decoder assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MFM_WRITE_INTERVAL_DECODER_ASSERT_SVH
`define MFM_WRITE_INTERVAL_DECODER_ASSERT_SVH

// Clocked check, muted while reset is applied.
`define MFMWD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define MFMWD_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mfmwd_pkg.sv
// ----------------------------------------------------------------------------
// MFM write interval decoder package
// Shared widths, codes, reset values and types.
// ----------------------------------------------------------------------------
package mfmwd_pkg;

	localparam int TS_W    = 16;
	localparam int ACC_W   = 16;
	localparam int CODE_W  = 2;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT   = 2'd3;

	// reset values of the thresholds (timer ticks)
	localparam logic [TS_W-1:0] RST_MIN_INTERVAL = 16'd200;
	localparam logic [TS_W-1:0] RST_SHORT_LIMIT  = 16'd360;
	localparam logic [TS_W-1:0] RST_MEDIUM_LIMIT = 16'd504;
	localparam logic [TS_W-1:0] RST_LONG_LIMIT   = 16'd650;

	// request opcodes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_GATE = 1'b1;

	// interval codes
	localparam logic [CODE_W-1:0] CODE_SKIP   = 2'd0;
	localparam logic [CODE_W-1:0] CODE_SHORT  = 2'd1;
	localparam logic [CODE_W-1:0] CODE_MEDIUM = 2'd2;
	localparam logic [CODE_W-1:0] CODE_LONG   = 2'd3;

	typedef struct packed {
		logic [TS_W-1:0] min_interval;
		logic [TS_W-1:0] short_limit;
		logic [TS_W-1:0] medium_limit;
		logic [TS_W-1:0] long_limit;
	} thresh_t;

	typedef struct packed {
		logic            op;
		logic [TS_W-1:0] timestamp;
	} item_t;

endpackage

### src/mfmwd_in_if.sv
// ----------------------------------------------------------------------------
// MFM write interval decoder request channel
// Valid/ready channel carrying edge timestamps and gate starts.
// ----------------------------------------------------------------------------
interface mfmwd_in_if;
	import mfmwd_pkg::*;

	logic            valid;
	logic            ready;
	logic            op;
	logic [TS_W-1:0] timestamp;

	modport source (output valid, output op, output timestamp, input ready);
	modport sink   (input valid, input op, input timestamp, output ready);
endinterface

### src/mfmwd_out_if.sv
// ----------------------------------------------------------------------------
// MFM write interval decoder result channel
// Valid/ready channel carrying packed interval codes.
// ----------------------------------------------------------------------------
interface mfmwd_out_if;
	import mfmwd_pkg::*;

	logic             valid;
	logic             ready;
	logic [ACC_W-1:0] packed_codes;

	modport source (output valid, output packed_codes, input ready);
	modport sink   (input valid, input packed_codes, output ready);
endinterface

### src/mfmwd_classify.sv
// ----------------------------------------------------------------------------
// MFM interval classifier
// Maps one interval to a 2-bit code against four ordered thresholds.
// ----------------------------------------------------------------------------
module mfmwd_classify (
	input  logic [mfmwd_pkg::TS_W-1:0]   interval,
	input  mfmwd_pkg::thresh_t           thresh,
	output logic [mfmwd_pkg::CODE_W-1:0] code
);
	import mfmwd_pkg::*;

	// first matching test wins
	always_comb begin
		if (interval < thresh.min_interval) begin
			code = CODE_SKIP;
		end else if (interval < thresh.short_limit) begin
			code = CODE_SHORT;
		end else if (interval < thresh.medium_limit) begin
			code = CODE_MEDIUM;
		end else if (interval < thresh.long_limit) begin
			code = CODE_LONG;
		end else begin
			code = CODE_SKIP;
		end
	end
endmodule

### src/mfmwd_pack.sv
// ----------------------------------------------------------------------------
// MFM code packer
// Holds the reference time and the code group, and the result register.
// ----------------------------------------------------------------------------
module mfmwd_pack #(
	parameter int GROUP_SIZE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  mfmwd_pkg::item_t   item_s1,
	input  mfmwd_pkg::thresh_t thresh,
	output logic               advance,
	mfmwd_out_if.source        result
);
	import mfmwd_pkg::*;

	localparam int PosW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam logic [PosW-1:0] LastPos = PosW'(GROUP_SIZE - 1);

	logic [TS_W-1:0]   last_time_q;
	logic [ACC_W-1:0]  acc_q;
	logic [PosW-1:0]   pos_q;
	logic [ACC_W-1:0]  res_q;
	logic              res_valid_q;

	logic [TS_W-1:0]   interval;
	logic [CODE_W-1:0] code;
	logic [ACC_W-1:0]  acc_next;
	logic              fire;
	logic              is_edge;
	logic              group_end;

	assign interval = item_s1.timestamp - last_time_q;   // wraps mod 2^16

	mfmwd_classify u_classify (
		.interval (interval),
		.thresh   (thresh),
		.code     (code)
	);

	assign advance   = !res_valid_q || result.ready;
	assign fire      = valid_s1 && advance;
	assign is_edge   = (item_s1.op == OP_EDGE);
	assign group_end = (pos_q == LastPos);
	assign acc_next  = (code != CODE_SKIP) ? {acc_q[ACC_W-CODE_W-1:0], code} : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			acc_q       <= '0;
			pos_q       <= '0;
		end else if (fire) begin
			last_time_q <= item_s1.timestamp;
			if (is_edge) begin
				if (group_end) begin
					acc_q <= '0;
					pos_q <= '0;
				end else begin
					acc_q <= acc_next;
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire && is_edge && group_end;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_edge && group_end) begin
			res_q <= acc_next;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.packed_codes = res_q;
endmodule

### src/mfm_write_interval_decoder.sv
// ----------------------------------------------------------------------------
// MFM write interval decoder
// Turns write-data edge timestamps into packed 2-bit MFM interval codes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  item    | in  | valid/ready   | op (edge / gate start), timestamp[15:0]
//  result  | out | valid/ready   | packed_codes[15:0], one word per group
//  cfg     | in  | cfg_we        | cfg_index[1:0], cfg_data[15:0]
//
//  One request per cycle sustained while the result side is not stalled.
//  Stage 1 is the input register, the packer's result register is stage 2.
//  The interval subtract and four threshold compares sit between them.
//  Reset clears the reference time, code group and both valid flags and
//  restores the default thresholds; no clearing pass is needed.
//  A stalled result holds stage 1; item.ready drops only while both hold.
// ----------------------------------------------------------------------------
module mfm_write_interval_decoder #(
	parameter int GROUP_SIZE = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mfmwd_in_if.sink                         item,
	mfmwd_out_if.source                      result,
	input  logic                             cfg_we,
	input  logic [mfmwd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfmwd_pkg::TS_W-1:0]       cfg_data
);
	import mfmwd_pkg::*;

	thresh_t thresh_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;

	// Threshold registers; the user must write them only while the decoder is idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.min_interval <= RST_MIN_INTERVAL;
			thresh_q.short_limit  <= RST_SHORT_LIMIT;
			thresh_q.medium_limit <= RST_MEDIUM_LIMIT;
			thresh_q.long_limit   <= RST_LONG_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_INTERVAL: thresh_q.min_interval <= cfg_data;
				CFG_SHORT_LIMIT:  thresh_q.short_limit  <= cfg_data;
				CFG_MEDIUM_LIMIT: thresh_q.medium_limit <= cfg_data;
				CFG_LONG_LIMIT:   thresh_q.long_limit   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 is free when empty or when it moves on this cycle.
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.op        <= item.op;
			item_s1.timestamp <= item.timestamp;
		end
	end

	// Interval, classification, packing and the result register.
	mfmwd_pack #(
		.GROUP_SIZE (GROUP_SIZE)
	) u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.thresh   (thresh_q),
		.advance  (advance),
		.result   (result)
	);
endmodule

### src/mfmwd_checker.sv
// ----------------------------------------------------------------------------
// MFM write interval decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "mfm_write_interval_decoder_assert.svh"

module mfmwd_checker #(
	parameter int GROUP_SIZE = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] result_packed_codes
);
	localparam int CodeBits = 2 * GROUP_SIZE;

	// a stalled result word keeps its value
	`MFMWD_ASSERT_CLK(a_result_hold, clk, arst_n, result_valid && !result_ready |=> result_valid && $stable(result_packed_codes), "result changed while stalled")

	// with no result pending the input side never stalls
	`MFMWD_ASSERT_CLK(a_ready_when_empty, clk, arst_n, !result_valid |-> item_ready, "item stalled with empty result slot")

	// a group holds at most GROUP_SIZE codes
	`MFMWD_ASSERT_CLK(a_group_width, clk, arst_n, result_valid |-> ((result_packed_codes >> CodeBits) == 16'd0), "codes beyond group size")

	// nothing comes out right after reset
	`MFMWD_ASSERT_RST(a_reset_quiet, clk, !arst_n |=> !result_valid, "result valid after reset")
endmodule

bind mfm_write_interval_decoder mfmwd_checker #(
	.GROUP_SIZE (GROUP_SIZE)
) u_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.item_ready          (item.ready),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.result_packed_codes (result.packed_codes)
);

### verif/tb_mfm_write_interval_decoder.sv
// ----------------------------------------------------------------------------
// MFM write interval decoder testbench
// Streams edge timestamps and gate starts through the decoder under several
// threshold settings. Each packed code word is checked against a local
// predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_mfm_write_interval_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import mfmwd_pkg::*;

	localparam int          GROUP        = 8;
	localparam int          N_SETTINGS   = 8;
	localparam int          REQS_PER_SET = 160;
	// pipeline is two deep; the slack also covers requests with no word out
	localparam int          DRAIN_SLACK  = 8;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;

	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TS_W-1:0]      cfg_data  = '0;

	mfmwd_in_if  item_if();
	mfmwd_out_if result_if();

	mfm_write_interval_decoder #(
		.GROUP_SIZE(GROUP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_if),
		.result   (result_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Clock, reset, watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		// known levels on every driven pin before the first edge
		item_if.valid     = 1'b0;
		item_if.op        = OP_EDGE;
		item_if.timestamp = '0;
		result_if.ready   = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	int unsigned cycle_count = 0;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// ------------------------------------------------------------------------
	// Predictor: local copy of thresholds and decoder state
	// ------------------------------------------------------------------------
	thresh_t          limits;
	logic [TS_W-1:0]  ref_time;
	logic [ACC_W-1:0] code_word;
	int               group_pos;

	logic [ACC_W-1:0] expected_words[$];

	int unsigned n_errors   = 0;
	int unsigned n_checked  = 0;
	int unsigned n_accepted = 0;
	int unsigned n_gates    = 0;
	int unsigned n_queued   = 0;

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("hung: %0d requests queued, %0d accepted, %0d words outstanding",
			n_queued, n_accepted, expected_words.size());
		$display("tb_mfm_write_interval_decoder failed");
		$finish;
	end

	initial begin
		limits    = '{RST_MIN_INTERVAL, RST_SHORT_LIMIT, RST_MEDIUM_LIMIT, RST_LONG_LIMIT};
		ref_time  = '0;
		code_word = '0;
		group_pos = 0;
	end

	// first matching test wins, so unordered thresholds just hide some codes
	function automatic logic [CODE_W-1:0] interval_code(input logic [TS_W-1:0] span);
		if (span < limits.min_interval)
			return CODE_SKIP;
		if (span < limits.short_limit)
			return CODE_SHORT;
		if (span < limits.medium_limit)
			return CODE_MEDIUM;
		if (span < limits.long_limit)
			return CODE_LONG;
		return CODE_SKIP;
	endfunction

	function automatic void predict_request(input logic op, input logic [TS_W-1:0] ts);
		logic [TS_W-1:0]   span;
		logic [CODE_W-1:0] code;
		if (op == OP_GATE) begin
			// gate start only moves the reference; group is untouched
			ref_time = ts;
			n_gates++;
			return;
		end
		span     = ts - ref_time;    // wraps modulo 2^16
		ref_time = ts;
		code     = interval_code(span);
		if (code != CODE_SKIP)
			code_word = {code_word[ACC_W-CODE_W-1:0], code};
		// skipped intervals still count toward the group
		if (group_pos + 1 >= GROUP) begin
			expected_words.push_back(code_word);
			code_word = '0;
			group_pos = 0;
		end else begin
			group_pos++;
		end
	endfunction

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		n_errors++;
	endtask

	// Per-request idle draw: bursts of random 0..9 waits, with some bursts
	// that run back to back.
	function automatic int unsigned draw_idle(inout bit quiet, inout int unsigned burst);
		if (burst == 0) begin
			quiet = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(8, 40);
		end
		burst--;
		return quiet ? 0 : $urandom_range(0, 9);
	endfunction

	// ------------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------------
	item_t       pending_reqs[$];
	item_t       drive_req;
	int unsigned src_wait  = 0;
	int unsigned src_burst = 0;
	bit          src_quiet = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid     <= 1'b0;
			item_if.op        <= OP_EDGE;
			item_if.timestamp <= '0;
			src_wait = 0;
		end else if (!item_if.valid || item_if.ready) begin
			// the request on the bus, if any, was taken at this edge
			if (item_if.valid) begin
				predict_request(item_if.op, item_if.timestamp);
				n_accepted++;
			end
			if (src_wait > 0) begin
				src_wait--;
				item_if.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				drive_req = pending_reqs.pop_front();
				item_if.valid     <= 1'b1;
				item_if.op        <= drive_req.op;
				item_if.timestamp <= drive_req.timestamp;
				src_wait = draw_idle(src_quiet, src_burst);
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor and checker
	// ------------------------------------------------------------------------
	int unsigned      sink_wait  = 0;
	int unsigned      sink_burst = 0;
	bit               sink_quiet = 1'b0;
	logic [ACC_W-1:0] want_word;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (expected_words.size() == 0) begin
					flag_mismatch($sformatf("word %04h with nothing expected",
						result_if.packed_codes));
				end else begin
					want_word = expected_words.pop_front();
					if (result_if.packed_codes !== want_word)
						flag_mismatch($sformatf("packed_codes %04h, expected %04h",
							result_if.packed_codes, want_word));
					n_checked++;
				end
				sink_wait = draw_idle(sink_quiet, sink_burst);
			end
			// a stall drawn here lands in front of the next word
			if (sink_wait > 0) begin
				sink_wait--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	// gen_time tracks the reference the decoder will hold once every queued
	// request is in, so spans can be aimed at the thresholds.
	logic [TS_W-1:0] gen_time = '0;

	function automatic void queue_request(input logic op, input logic [TS_W-1:0] ts);
		item_t req;
		req.op        = op;
		req.timestamp = ts;
		pending_reqs.push_back(req);
		gen_time = ts;
		n_queued++;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TS_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// only called with the pipe empty
	task automatic load_thresholds(input thresh_t t);
		write_reg(CFG_MIN_INTERVAL, t.min_interval);
		write_reg(CFG_SHORT_LIMIT, t.short_limit);
		write_reg(CFG_MEDIUM_LIMIT, t.medium_limit);
		write_reg(CFG_LONG_LIMIT, t.long_limit);
		limits = t;
	endtask

	// everything queued has been taken, every word checked, pipe flushed
	task automatic wait_drained();
		do
			@(posedge clk);
		while (n_accepted != n_queued || expected_words.size() != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	initial begin : stimulus
		thresh_t         setting;
		int              level;
		int              span_hi;
		int unsigned     roll;
		logic [TS_W-1:0] near;
		logic [TS_W-1:0] span;

		wait (arst_n === 1'b1);
		@(posedge clk);

		// --- directed, on reset thresholds ---
		// each threshold boundary and the tick below it
		queue_request(OP_GATE, 16'd0);
		queue_request(OP_EDGE, gen_time + 16'd199);   // under min: skipped
		queue_request(OP_EDGE, gen_time + 16'd200);   // short
		queue_request(OP_EDGE, gen_time + 16'd359);
		queue_request(OP_EDGE, gen_time + 16'd360);   // medium
		queue_request(OP_EDGE, gen_time + 16'd503);
		queue_request(OP_EDGE, gen_time + 16'd504);   // long
		queue_request(OP_EDGE, gen_time + 16'd649);
		queue_request(OP_EDGE, gen_time + 16'd650);   // at long limit: skipped
		// timer wrap, zero span, gate start in the middle of a group
		queue_request(OP_GATE, 16'd65400);
		queue_request(OP_EDGE, 16'd164);              // 300 ticks across the wrap
		queue_request(OP_EDGE, gen_time);             // zero interval
		queue_request(OP_GATE, 16'hFFFF);
		queue_request(OP_EDGE, 16'h01F3);             // 500 ticks across the wrap
		queue_request(OP_EDGE, gen_time + 16'hFFFF);  // widest interval
		queue_request(OP_EDGE, gen_time + 16'd600);
		queue_request(OP_EDGE, gen_time + 16'd400);
		queue_request(OP_EDGE, gen_time + 16'd250);
		queue_request(OP_EDGE, gen_time + 16'd360);
		wait_drained();

		// --- random, one threshold setting per pass ---
		for (int p = 0; p < N_SETTINGS; p++) begin
			case (p)
				0: setting = '{RST_MIN_INTERVAL, RST_SHORT_LIMIT,
					RST_MEDIUM_LIMIT, RST_LONG_LIMIT};
				1: setting = '0;                            // everything skipped
				2: setting = '1;                            // everything skipped too
				3: setting = '{16'd500, 16'd100, 16'd800, 16'd700};  // out of order
				4: setting = '{16'd0, 16'd1, 16'd2, 16'hFFFF};       // widest long band
				6: begin
					setting.min_interval = 16'($urandom_range(0, 1500));
					setting.short_limit  = 16'($urandom_range(0, 1500));
					setting.medium_limit = 16'($urandom_range(0, 1500));
					setting.long_limit   = 16'($urandom_range(0, 1500));
				end
				default: begin
					// ascending, random spacing
					level = $urandom_range(0, 3000);
					setting.min_interval = 16'(level);
					level += $urandom_range(0, 400);
					setting.short_limit = 16'(level);
					level += $urandom_range(0, 400);
					setting.medium_limit = 16'(level);
					level += $urandom_range(0, 400);
					setting.long_limit = 16'(level);
				end
			endcase
			load_thresholds(setting);

			span_hi = int'(limits.min_interval);
			if (int'(limits.short_limit) > span_hi)
				span_hi = int'(limits.short_limit);
			if (int'(limits.medium_limit) > span_hi)
				span_hi = int'(limits.medium_limit);
			if (int'(limits.long_limit) > span_hi)
				span_hi = int'(limits.long_limit);
			span_hi = (span_hi + 64 > 65535) ? 65535 : span_hi + 64;

			for (int k = 0; k < REQS_PER_SET; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					queue_request(OP_GATE, 16'($urandom_range(0, 65535)));
				end else if (roll < 11) begin
					// stray edge anywhere on the timer
					queue_request(OP_EDGE, 16'($urandom_range(0, 65535)));
				end else begin
					case ($urandom_range(0, 3))
						0: near = limits.min_interval;
						1: near = limits.short_limit;
						2: near = limits.medium_limit;
						default: near = limits.long_limit;
					endcase
					if ($urandom_range(0, 2) == 0)
						span = 16'($urandom_range(0, span_hi));
					else
						span = near + 16'($urandom_range(0, 4)) - 16'd2;  // hug a boundary
					queue_request(OP_EDGE, gen_time + span);
				end
			end
			wait_drained();
		end

		$display("%0d requests (%0d gate starts) over %0d threshold settings",
			n_accepted, n_gates, N_SETTINGS + 1);
		$display("%0d code words checked, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0)
			$display("tb_mfm_write_interval_decoder passed");
		else
			$display("tb_mfm_write_interval_decoder failed");
		$finish;
	end

endmodule
